// ===== rtl/srtf_pkg.sv =====
// shared types, widths and constants of the srtf scheduler
`timescale 1ns / 1ps

package srtf_pkg;

    localparam int MAX_PROCESSES_DEF = 16;

    localparam int KIND_W  = 1;
    localparam int SLOT_W  = 4;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 12;
    localparam int TIME_W  = 17;
    localparam int PID_W   = 5;
    localparam int COUNT_W = 5;

    localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] DONE_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    // ram word: arrival, burst, remaining
    localparam int ENTRY_W = ARR_W + BURST_W + BURST_W;

    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_TICK = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [ARR_W-1:0]   arrive_tick;
        logic [BURST_W-1:0] burst_len;
    } request_t;

    typedef struct packed {
        logic              ran;
        logic [PID_W-1:0]  process_id;
        logic              finished;
        logic [TIME_W-1:0] completion_tick;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } result_t;

endpackage

// ===== rtl/srtf_preemptive_scheduler_core.sv =====
// top level of the preemptive shortest-remaining-time-first scheduler
//
// channel   | signals                  | handshake
// ----------+--------------------------+------------------------------------------
// request   | start, busy, request     | taken at a clock edge with start and !busy
// result    | result_valid, result     | one-cycle strobe, cannot be held off
// config    | cfg_we, cfg_data         | written at a clock edge with cfg_we
//
// a load request is written into the ram as it is taken and gives no result; busy stays low
// a tick request keeps busy high through the slot scan (one slot a cycle through
//   the ram read port), the decision and the result, and through the bit-serial
//   turnaround and waiting subtraction when the process finishes
// reset is asynchronous and clears remaining-time valid bits, time and the done
//   counter, and sets the slot count to one; there is no clearing pass
// the result strobe shows while busy is already low, so the next request can
//   be taken in that same cycle; the receiver cannot stall
`timescale 1ns / 1ps

module srtf_preemptive_scheduler_core #(
    parameter int MAX_PROCESSES = srtf_pkg::MAX_PROCESSES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  srtf_pkg::request_t           request,
    output logic                         result_valid,
    output srtf_pkg::result_t            result,
    input  logic                         cfg_we,
    input  logic [srtf_pkg::COUNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);
    localparam int EW = srtf_pkg::ENTRY_W;
    localparam int BW = srtf_pkg::BURST_W;
    localparam int TW = srtf_pkg::TIME_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SERIAL
    } state_t;

    state_t state_reg, state_next;

    logic [srtf_pkg::COUNT_W-1:0] pcount_reg, pcount_next;
    logic [TW-1:0]                time_reg, time_next;
    logic [srtf_pkg::COUNT_W-1:0] done_cnt_reg, done_cnt_next;
    logic [MAX_PROCESSES-1:0]     valid_reg, valid_next;

    // scan control
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] data_idx_reg, data_idx_next;
    logic          pend_reg, pend_next;
    logic          data_ok_reg, data_ok_next;

    // running minimum
    logic                        found_reg, found_next;
    logic [AW-1:0]               pick_reg, pick_next;
    logic [BW-1:0]               best_rem_reg, best_rem_next;
    logic [srtf_pkg::ARR_W-1:0]  best_arr_reg, best_arr_next;
    logic [BW-1:0]               best_burst_reg, best_burst_next;

    srtf_pkg::result_t result_reg, result_next;
    logic              strobe_reg, strobe_next;

    // ram port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // serial unit
    logic          sub_start;
    logic          sub_done;
    logic [TW-1:0] sub_tat;
    logic [TW-1:0] sub_wait;

    logic [CW-1:0]              count_eff;
    logic                       accept;
    logic                       load_ok;
    logic                       issue;
    logic [srtf_pkg::ARR_W-1:0] rd_arr;
    logic [BW-1:0]              rd_burst;
    logic [BW-1:0]              rd_rem;
    logic                       eligible;
    logic [TW-1:0]              time_inc;
    logic [srtf_pkg::PID_W-1:0] pid;

    // slot count saturates at the number of slots built
    assign count_eff = (int'(pcount_reg) > MAX_PROCESSES) ? CW'(MAX_PROCESSES)
                                                          : CW'(pcount_reg);

    assign accept  = start && (state_reg == ST_IDLE);
    assign load_ok = accept && (request.kind == srtf_pkg::KIND_LOAD)
                     && (int'(request.slot) < MAX_PROCESSES);
    assign issue   = (state_reg == ST_SCAN) && (idx_reg < count_eff);

    assign ram_raddr = idx_reg[AW-1:0];

    assign rd_arr   = ram_rdata[EW-1 -: srtf_pkg::ARR_W];
    assign rd_burst = ram_rdata[2*BW-1 -: BW];
    // a slot never loaded has no work left
    assign rd_rem   = data_ok_reg ? ram_rdata[BW-1:0] : '0;

    assign eligible = pend_reg && (rd_rem != '0)
                      && ({1'b0, rd_arr} <= time_reg)
                      && (!found_reg || (rd_rem < best_rem_reg));

    assign time_inc = (time_reg == srtf_pkg::TIME_MAX) ? time_reg : time_reg + TW'(1);
    assign pid      = srtf_pkg::PID_W'(int'(pick_reg) + 1);

    always_comb
    begin
        state_next      = state_reg;
        pcount_next     = pcount_reg;
        time_next       = time_reg;
        done_cnt_next   = done_cnt_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        data_idx_next   = data_idx_reg;
        pend_next       = 1'b0;
        data_ok_next    = 1'b0;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_rem_next   = best_rem_reg;
        best_arr_next   = best_arr_reg;
        best_burst_next = best_burst_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        sub_start       = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = AW'(request.slot);
        ram_wdata = {request.arrive_tick, request.burst_len, request.burst_len};

        if (cfg_we)
        begin
            pcount_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (load_ok)
                begin
                    ram_we = 1'b1;
                    valid_next[AW'(request.slot)] = 1'b1;
                end
                if (accept && (request.kind == srtf_pkg::KIND_TICK))
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // one slot issued to the ram per cycle, compared in the cycle after
                if (issue)
                begin
                    idx_next      = idx_reg + CW'(1);
                    data_idx_next = idx_reg[AW-1:0];
                    pend_next     = 1'b1;
                    data_ok_next  = valid_reg[idx_reg[AW-1:0]];
                end
                if (eligible)
                begin
                    found_next      = 1'b1;
                    pick_next       = data_idx_reg;
                    best_rem_next   = rd_rem;
                    best_arr_next   = rd_arr;
                    best_burst_next = rd_burst;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                time_next   = time_inc;
                result_next = '0;
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pick_reg;
                    ram_wdata = {best_arr_reg, best_burst_reg, best_rem_reg - BW'(1)};
                    result_next.ran        = 1'b1;
                    result_next.process_id = pid;
                end
                if (found_reg && (best_rem_reg == BW'(1)))
                begin
                    // last tick of work: times come from the serial unit
                    if (done_cnt_reg != srtf_pkg::DONE_MAX)
                    begin
                        done_cnt_next = done_cnt_reg + srtf_pkg::COUNT_W'(1);
                    end
                    sub_start  = 1'b1;
                    state_next = ST_SERIAL;
                end
                else
                begin
                    result_next.all_done = (int'(done_cnt_reg) >= int'(count_eff));
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_SERIAL:
            begin
                if (sub_done)
                begin
                    result_next.ran             = 1'b1;
                    result_next.process_id      = pid;
                    result_next.finished        = 1'b1;
                    result_next.completion_tick = time_reg;
                    result_next.turnaround      = sub_tat;
                    result_next.waiting         = sub_wait;
                    result_next.all_done = (int'(done_cnt_reg) >= int'(count_eff));
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pcount_reg     <= srtf_pkg::COUNT_RESET;
            time_reg       <= '0;
            done_cnt_reg   <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            data_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            data_ok_reg    <= 1'b0;
            found_reg      <= 1'b0;
            pick_reg       <= '0;
            best_rem_reg   <= '0;
            best_arr_reg   <= '0;
            best_burst_reg <= '0;
            result_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pcount_reg     <= pcount_next;
            time_reg       <= time_next;
            done_cnt_reg   <= done_cnt_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            data_idx_reg   <= data_idx_next;
            pend_reg       <= pend_next;
            data_ok_reg    <= data_ok_next;
            found_reg      <= found_next;
            pick_reg       <= pick_next;
            best_rem_reg   <= best_rem_next;
            best_arr_reg   <= best_arr_next;
            best_burst_reg <= best_burst_next;
            result_reg     <= result_next;
            strobe_reg     <= strobe_next;
        end
    end

    // arrival, burst and remaining time per slot
    srtf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCESSES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // completion time is the already advanced time register
    srtf_serial_sub u_sub (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (sub_start),
        .comp       (time_next),
        .arr        (best_arr_reg),
        .burst      (best_burst_reg),
        .done       (sub_done),
        .turnaround (sub_tat),
        .waiting    (sub_wait)
    );

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = strobe_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/srtf_ram.sv =====
// generic single write, single registered read ram
`timescale 1ns / 1ps

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/srtf_serial_sub.sv =====
// bit-serial unit for turnaround and waiting times, lsb first, saturating at zero
`timescale 1ns / 1ps

module srtf_serial_sub (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [srtf_pkg::TIME_W-1:0]  comp,
    input  logic [srtf_pkg::ARR_W-1:0]   arr,
    input  logic [srtf_pkg::BURST_W-1:0] burst,
    output logic                         done,
    output logic [srtf_pkg::TIME_W-1:0]  turnaround,
    output logic [srtf_pkg::TIME_W-1:0]  waiting
);

    localparam int TW  = srtf_pkg::TIME_W;
    localparam int CNW = $clog2(TW + 1);

    logic [TW-1:0]  a_reg, a_next;
    logic [TW-1:0]  b_reg, b_next;
    logic [TW-1:0]  c_reg, c_next;
    logic [TW-1:0]  tat_reg, tat_next;
    logic [TW-1:0]  wait_reg, wait_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           br1_reg, br1_next;
    logic           br2_reg, br2_next;
    logic           done_reg, done_next;

    logic d1, d2;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        tat_next  = tat_reg;
        wait_next = wait_reg;
        cnt_next  = cnt_reg;
        br1_next  = br1_reg;
        br2_next  = br2_reg;
        done_next = 1'b0;

        // tat bit, then burst taken off that same bit
        d1 = a_reg[0] ^ b_reg[0] ^ br1_reg;
        d2 = d1 ^ c_reg[0] ^ br2_reg;

        if (start)
        begin
            a_next   = comp;
            b_next   = TW'(arr);
            c_next   = TW'(burst);
            cnt_next = CNW'(TW);
            br1_next = 1'b0;
            br2_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            br1_next  = (~a_reg[0] & b_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & br1_reg);
            br2_next  = (~d1 & c_reg[0]) | (~(d1 ^ c_reg[0]) & br2_reg);
            a_next    = {1'b0, a_reg[TW-1:1]};
            b_next    = {1'b0, b_reg[TW-1:1]};
            c_next    = {1'b0, c_reg[TW-1:1]};
            tat_next  = {d1, tat_reg[TW-1:1]};
            wait_next = {d2, wait_reg[TW-1:1]};
            cnt_next  = cnt_reg - CNW'(1);
            done_next = (cnt_reg == CNW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            br1_reg  <= 1'b0;
            br2_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            br1_reg  <= br1_next;
            br2_reg  <= br2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        tat_reg  <= tat_next;
        wait_reg <= wait_next;
    end

    // final borrow means the difference went below zero
    assign done       = done_reg;
    assign turnaround = br1_reg ? '0 : tat_reg;
    assign waiting    = (br1_reg || br2_reg) ? '0 : wait_reg;

endmodule

// ===== rtl/srtf_checker.sv =====
// port-level assertions for the srtf scheduler, with bind
`timescale 1ns / 1ps

module srtf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input srtf_pkg::request_t request,
    input logic               result_valid,
    input srtf_pkg::result_t  result
);

    // results only show once the block is free again
    a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // a tick request always occupies the block
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.kind == srtf_pkg::KIND_TICK) |=> busy)
        else $error("tick request not followed by busy");

    // a load gives no result and leaves the block free
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.kind == srtf_pkg::KIND_LOAD) |=> (!busy && !result_valid))
        else $error("load request produced a result or busy");

    // an idle tick reports nothing
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.ran) |-> (result.process_id == '0 && !result.finished))
        else $error("idle tick with process fields set");

    // only a process that ran can finish
    a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.finished) |-> (result.ran && result.process_id != '0))
        else $error("finished without a running process");

endmodule

bind srtf_preemptive_scheduler_core srtf_checker u_srtf_checker (.*);

// ===== tb/sv/srtf_preemptive_scheduler_core_tb.sv =====
// self-checking testbench of the srtf scheduler core, with its own scheduling predictor
`timescale 1ns / 1ps

module srtf_preemptive_scheduler_core_tb;

    // a tick keeps the block busy through scan, decision and result, and through
    // the serial subtraction when a process finishes
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 4;
    localparam int PHASE_REQUESTS = 395;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    srtf_pkg::request_t request;
    logic result_valid;
    srtf_pkg::result_t result;
    logic cfg_we;
    logic [srtf_pkg::COUNT_W-1:0] cfg_data;

    // predicted scheduler state
    logic [srtf_pkg::ARR_W-1:0] arrival_of [srtf_pkg::MAX_PROCESSES_DEF];
    logic [srtf_pkg::BURST_W-1:0] burst_of [srtf_pkg::MAX_PROCESSES_DEF];
    logic [srtf_pkg::BURST_W-1:0] remaining_of [srtf_pkg::MAX_PROCESSES_DEF];
    logic [srtf_pkg::TIME_W-1:0] sched_now;
    logic [srtf_pkg::COUNT_W-1:0] finished_total;
    logic [srtf_pkg::COUNT_W-1:0] slot_count;

    // tick outcomes still owed by the block, oldest first
    srtf_pkg::result_t tick_outcomes [$];

    int mismatch_count = 0;
    int requests_sent = 0;
    int sender_idle_pct = 0;

    srtf_preemptive_scheduler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // slots that take part: the register value, capped at the table depth
    function automatic int unsigned live_slots();
        return (int'(slot_count) > srtf_pkg::MAX_PROCESSES_DEF) ? srtf_pkg::MAX_PROCESSES_DEF
                                                                 : int'(slot_count);
    endfunction

    // a load overwrites the slot and restarts its remaining work
    function automatic void store_process(input srtf_pkg::request_t r);
        arrival_of[r.slot] = r.arrive_tick;
        burst_of[r.slot] = r.burst_len;
        remaining_of[r.slot] = r.burst_len;
    endfunction

    // one scheduler tick: pick the shortest remaining eligible slot, run it
    function automatic srtf_pkg::result_t run_one_tick();
        srtf_pkg::result_t o;
        int unsigned eff;
        int unsigned i;
        int unsigned pick;
        logic found;
        logic [srtf_pkg::BURST_W-1:0] best;
        logic [srtf_pkg::TIME_W-1:0] tat;
        logic [srtf_pkg::TIME_W-1:0] wt;
        o = '0;
        eff = live_slots();
        found = 1'b0;
        pick = 0;
        best = '0;
        // strict less-than keeps the lowest slot on a tie
        for (i = 0; i < eff; i++)
        begin
            if (srtf_pkg::TIME_W'(arrival_of[i]) <= sched_now && remaining_of[i] != '0 &&
                (!found || remaining_of[i] < best))
            begin
                found = 1'b1;
                best = remaining_of[i];
                pick = i;
            end
        end
        // time still moves on an idle tick, but stops at its ceiling
        if (sched_now != srtf_pkg::TIME_MAX)
            sched_now = sched_now + srtf_pkg::TIME_W'(1);
        if (found)
        begin
            o.ran = 1'b1;
            o.process_id = srtf_pkg::PID_W'(pick) + srtf_pkg::PID_W'(1);
            remaining_of[pick] = remaining_of[pick] - srtf_pkg::BURST_W'(1);
            if (remaining_of[pick] == '0)
            begin
                o.finished = 1'b1;
                o.completion_tick = sched_now;
                tat = (sched_now >= srtf_pkg::TIME_W'(arrival_of[pick])) ?
                      sched_now - srtf_pkg::TIME_W'(arrival_of[pick]) : '0;
                wt = (tat >= srtf_pkg::TIME_W'(burst_of[pick])) ?
                     tat - srtf_pkg::TIME_W'(burst_of[pick]) : '0;
                o.turnaround = tat;
                o.waiting = wt;
                if (finished_total != srtf_pkg::DONE_MAX)
                    finished_total = finished_total + srtf_pkg::COUNT_W'(1);
            end
        end
        o.all_done = (finished_total >= srtf_pkg::COUNT_W'(eff));
        return o;
    endfunction

    task automatic report_field(input string what, input logic [srtf_pkg::TIME_W-1:0] want,
                                input logic [srtf_pkg::TIME_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // every strobed result is matched against the oldest owed outcome
    always @(posedge clk)
    begin : check_results
        srtf_pkg::result_t want;
        if (rst_n && result_valid)
        begin
            if (tick_outcomes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result expected none got ran=%0d id=%0d fin=%0d",
                         $time, result.ran, result.process_id, result.finished);
            end
            else
            begin
                want = tick_outcomes.pop_front();
                report_field("ran", srtf_pkg::TIME_W'(want.ran),
                             srtf_pkg::TIME_W'(result.ran));
                report_field("process_id", srtf_pkg::TIME_W'(want.process_id),
                             srtf_pkg::TIME_W'(result.process_id));
                report_field("finished", srtf_pkg::TIME_W'(want.finished),
                             srtf_pkg::TIME_W'(result.finished));
                report_field("completion_tick", want.completion_tick, result.completion_tick);
                report_field("turnaround", want.turnaround, result.turnaround);
                report_field("waiting", want.waiting, result.waiting);
                report_field("all_done", srtf_pkg::TIME_W'(want.all_done),
                             srtf_pkg::TIME_W'(result.all_done));
            end
        end
    end

    // offer one request; it is taken at the first edge with busy low
    task automatic send_request(input srtf_pkg::request_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        request <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.kind == srtf_pkg::KIND_TICK)
            tick_outcomes.push_back(run_one_tick());
        else
            store_process(r);
        requests_sent++;
    endtask

    task automatic send_load(input logic [srtf_pkg::SLOT_W-1:0] slot,
                             input logic [srtf_pkg::ARR_W-1:0] arr,
                             input logic [srtf_pkg::BURST_W-1:0] len);
        srtf_pkg::request_t r;
        r.kind = srtf_pkg::KIND_LOAD;
        r.slot = slot;
        r.arrive_tick = arr;
        r.burst_len = len;
        send_request(r);
    endtask

    // tick requests carry random noise in the fields the block ignores
    task automatic send_ticks(input int unsigned n);
        srtf_pkg::request_t r;
        repeat (n)
        begin
            r.kind = srtf_pkg::KIND_TICK;
            r.slot = srtf_pkg::SLOT_W'($urandom);
            r.arrive_tick = srtf_pkg::ARR_W'($urandom);
            r.burst_len = srtf_pkg::BURST_W'($urandom);
            send_request(r);
        end
    endtask

    // hold off until every owed result is in and the block has gone quiet
    task automatic drain_results();
        start <= 1'b0;
        while (tick_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic set_process_count(input logic [srtf_pkg::COUNT_W-1:0] n);
        cfg_data <= n;
        cfg_we <= 1'b1;
        @(posedge clk);
        slot_count = n;
        cfg_we <= 1'b0;
    endtask

    // every slot gets written first, so no tick ever scans an unwritten entry;
    // far-off arrivals keep them out of the way, then one idle tick at reset count
    task automatic test_fill_slots();
        int unsigned i;
        for (i = 0; i < srtf_pkg::MAX_PROCESSES_DEF; i++)
            send_load(srtf_pkg::SLOT_W'(i), '1,
                      (i % 3 == 0) ? 12'hFFF : (i % 3 == 1) ? 12'hAAA : 12'h555);
        send_ticks(1);
        drain_results();
    endtask

    // no slot takes part: idle ticks with all_done raised
    task automatic test_count_zero();
        set_process_count('0);
        send_ticks(2);
        drain_results();
    endtask

    // count above the table saturates; shorter job pre-empts, tie goes to the lower slot,
    // last slot gives the highest process id, arrival zero is eligible at once
    task automatic test_preemption_and_ties();
        logic [srtf_pkg::ARR_W-1:0] t;
        set_process_count('1);
        t = srtf_pkg::ARR_W'(sched_now);
        send_load(4'd0, t, 12'd3);
        send_load(4'd1, t, 12'd3);
        send_load(4'd2, t + srtf_pkg::ARR_W'(1), 12'd1);
        send_load(4'd15, '0, 12'd2);
        send_ticks(10);
        drain_results();
    endtask

    // reload of a finished slot runs again; a slot above the count stays parked
    task automatic test_reload_and_parked_slot();
        logic [srtf_pkg::ARR_W-1:0] t;
        set_process_count(srtf_pkg::COUNT_W'(4));
        t = srtf_pkg::ARR_W'(sched_now);
        send_load(4'd1, t, 12'd2);
        send_load(4'd9, t, 12'd1);
        send_ticks(4);
        drain_results();
    endtask

    // a well-formed burst of work: a few near-term jobs, then enough ticks to run them
    task automatic random_batch();
        int unsigned eff;
        int unsigned loads;
        int unsigned work;
        int unsigned k;
        logic [srtf_pkg::ARR_W-1:0] arr;
        logic [srtf_pkg::BURST_W-1:0] len;
        eff = live_slots();
        loads = $urandom_range(1, (eff < 4) ? eff : 4);
        work = 0;
        for (k = 0; k < loads; k++)
        begin
            arr = (sched_now < 17'd65000) ?
                  srtf_pkg::ARR_W'(sched_now + $urandom_range(0, 6)) :
                  srtf_pkg::ARR_W'($urandom);
            len = ($urandom_range(0, 9) == 0) ? srtf_pkg::BURST_W'($urandom_range(11, 60))
                                              : srtf_pkg::BURST_W'($urandom_range(1, 10));
            send_load(srtf_pkg::SLOT_W'($urandom_range(0, eff - 1)), arr, len);
            work += int'(len);
        end
        work += $urandom_range(0, 3);
        send_ticks((work > 80) ? 80 : work);
    endtask

    // stray requests over the full slot and arrival ranges, with any nonzero burst
    task automatic random_noise();
        if ($urandom_range(0, 1) == 0)
            send_ticks(1);
        else
            send_load(srtf_pkg::SLOT_W'($urandom_range(0, 15)),
                      srtf_pkg::ARR_W'($urandom_range(0, 65535)),
                      srtf_pkg::BURST_W'($urandom_range(1, 4095)));
    endtask

    // phases differ in count and in how often the sender sits idle
    task automatic test_random_traffic();
        int unsigned phase;
        int phase_end;
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    set_process_count(srtf_pkg::COUNT_W'(16));
                    sender_idle_pct = 0;
                end
                1:
                begin
                    set_process_count(srtf_pkg::COUNT_W'($urandom_range(2, 15)));
                    sender_idle_pct = 61;
                end
                2:
                begin
                    set_process_count(srtf_pkg::COUNT_W'(1));
                    sender_idle_pct = 37;
                end
                default:
                begin
                    set_process_count(srtf_pkg::COUNT_W'(17));
                    sender_idle_pct = 0;
                end
            endcase
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    random_noise();
                else
                    random_batch();
                // now and then let the pipeline run completely dry
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
        end
        sender_idle_pct = 0;
        drain_results();
    endtask

    // idle ticks at count zero leave loaded work untouched; then two jobs that
    // arrived at tick zero finish late, giving large turnaround and waiting figures
    task automatic test_late_finish();
        set_process_count('0);
        send_load(4'd0, '0, 12'd2);
        send_load(4'd1, '0, 12'd1);
        send_ticks(2);
        drain_results();
        set_process_count(srtf_pkg::COUNT_W'(2));
        send_ticks(4);
        drain_results();
    endtask

    initial
    begin
        int unsigned i;
        rst_n <= 1'b0;
        start <= 1'b0;
        request <= '0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        for (i = 0; i < srtf_pkg::MAX_PROCESSES_DEF; i++)
        begin
            arrival_of[i] = '0;
            burst_of[i] = '0;
            remaining_of[i] = '0;
        end
        sched_now = '0;
        finished_total = '0;
        slot_count = srtf_pkg::COUNT_RESET;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_slots();
        test_count_zero();
        test_preemption_and_ties();
        test_reload_and_parked_slot();
        test_random_traffic();
        test_late_finish();

        drain_results();
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
